### sv/gppa_pkg.sv
// Shared types and fixed widths for the gated peak pair averager.
// No dependencies; used by the divider, the averager, the checker and the testbench top through scoped names.
`default_nettype none
package gppa_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int COUNT_W     = 7;
   localparam int FRAC_W      = 8;
   localparam int FIXED_W     = 20;
   localparam int COUNT_LIMIT = 127;

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] plus_avg_rounded;
      logic [SAMPLE_W-1:0] minus_avg_rounded;
      logic [FIXED_W-1:0]  plus_avg_fixed;
      logic [FIXED_W-1:0]  minus_avg_fixed;
      logic [COUNT_W-1:0]  pairs_used;
   } rsp_type;

endpackage
`default_nettype wire

### sv/gppa_div.sv
// Restoring divider, one quotient bit per cycle, shared for both channel averages.
// Depends on gppa_pkg for the divisor width.
`default_nettype none
module gppa_div #(
   parameter int DIVIDEND_W = 27
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DIVIDEND_W-1:0]         dividend,
   input  wire logic [gppa_pkg::COUNT_W-1:0]  divisor,
   output logic                               done,
   output logic [DIVIDEND_W-1:0]              quotient
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam int DV_W  = gppa_pkg::COUNT_W;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DV_W-1:0]       rem_ff, rem_in;
   logic [DV_W-1:0]       div_ff, div_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DV_W:0]         shifted;
   logic [DV_W+1:0]       diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // shift the next dividend bit in, keep the difference if it fits
         if (!diff[DV_W+1]) begin
            rem_in = diff[DV_W-1:0];
         end else begin
            rem_in = shifted[DV_W-1:0];
         end
         quo_in = {quo_ff[DIVIDEND_W-2:0], ~diff[DV_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### sv/gated_peak_pair_averager.sv
// Gated peak pair averager. Sample and window-end transactions are taken one per
// cycle while req_stall is low. The window end that completes the last pulse pair
// starts two divisions on one shared bit-serial divider, plus channel then minus
// channel, each on a (SUM_W+8)-bit dividend, and then loads the result register;
// req_stall is high during that time and while a new result waits for the
// previous one to be taken.
// A result transaction carries both averages rounded to nearest and in
// 8-fraction-bit fixed point, truncated.
// Depends on gppa_pkg and gppa_div.
`default_nettype none
module gated_peak_pair_averager #(
   parameter int MAX_PULSES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire gppa_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output gppa_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [gppa_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int CAP   = (MAX_PULSES < gppa_pkg::COUNT_LIMIT) ? MAX_PULSES
                                                                : gppa_pkg::COUNT_LIMIT;
   localparam int SUM_W = $clog2(CAP * ((1 << gppa_pkg::SAMPLE_W) - 1) + 1);
   localparam int DW    = SUM_W + gppa_pkg::FRAC_W;
   localparam int CW    = gppa_pkg::COUNT_W;
   localparam int SW    = gppa_pkg::SAMPLE_W;
   localparam int FW    = gppa_pkg::FIXED_W;
   localparam int RB    = gppa_pkg::FRAC_W;
   localparam logic [CW-1:0] CAP_N = CW'(CAP);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV_P = 2'd1;
   localparam logic [1:0] ST_DIV_M = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [SW-1:0]    peak_ff, peak_in;
   logic [SUM_W-1:0] plus_sum_ff, plus_sum_in;
   logic [SUM_W-1:0] minus_sum_ff, minus_sum_in;
   logic [CW-1:0]    pairs_ff, pairs_in;
   logic             minus_ch_ff, minus_ch_in;
   logic [SUM_W-1:0] minus_hold_ff, minus_hold_in;
   logic [CW-1:0]    n_hold_ff, n_hold_in;
   logic [DW-1:0]    q_plus_ff, q_plus_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gppa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             last_pair;
   logic [CW-1:0]    n_clamped;
   logic [CW-1:0]    pairs_next;
   logic [SUM_W-1:0] minus_total;
   logic             div_start;
   logic [DW-1:0]    div_dividend;
   logic             div_done;
   logic [DW-1:0]    div_quotient;
   logic             out_free;
   logic [DW:0]      round_p;
   logic [DW:0]      round_m;

   gppa_div #(
      .DIVIDEND_W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_hold_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      if (count_ff == '0) begin
         n_clamped = CW'(1);
      end else if (count_ff > CAP_N) begin
         n_clamped = CAP_N;
      end else begin
         n_clamped = count_ff;
      end
   end

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign pairs_next  = pairs_ff + 1'b1;
   assign minus_total = minus_sum_ff + SUM_W'(peak_ff);
   assign last_pair   = req_data.mode && minus_ch_ff && (pairs_next >= n_clamped);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // rounded = floor((Q + 1/2 LSB of integer) / 256) where Q = floor(256*S/n)
   assign round_p = {1'b0, q_plus_ff} + (DW+1)'(1 << (RB - 1));
   assign round_m = {1'b0, div_quotient} + (DW+1)'(1 << (RB - 1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      plus_sum_in   = plus_sum_ff;
      minus_sum_in  = minus_sum_ff;
      pairs_in      = pairs_ff;
      minus_ch_in   = minus_ch_ff;
      minus_hold_in = minus_hold_ff;
      n_hold_in     = n_hold_ff;
      q_plus_in     = q_plus_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = {minus_hold_ff, RB'(0)};

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_data.mode) begin
                  if (req_data.sample > peak_ff) begin
                     peak_in = req_data.sample;
                  end
               end else if (!minus_ch_ff) begin
                  plus_sum_in = plus_sum_ff + SUM_W'(peak_ff);
                  peak_in     = '0;
                  minus_ch_in = 1'b1;
               end else begin
                  peak_in     = '0;
                  minus_ch_in = 1'b0;
                  if (last_pair) begin
                     // hold operands and clear accumulation for the next run
                     minus_hold_in = minus_total;
                     n_hold_in     = n_clamped;
                     div_start     = 1'b1;
                     div_dividend  = {plus_sum_ff, RB'(0)};
                     plus_sum_in   = '0;
                     minus_sum_in  = '0;
                     pairs_in      = '0;
                     state_in      = ST_DIV_P;
                  end else begin
                     minus_sum_in = minus_total;
                     pairs_in     = pairs_next;
                  end
               end
            end
         end
         ST_DIV_P: begin
            if (div_done) begin
               q_plus_in    = div_quotient;
               div_start    = 1'b1;
               div_dividend = {minus_hold_ff, RB'(0)};
               state_in     = ST_DIV_M;
            end
         end
         ST_DIV_M: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.plus_avg_rounded  = round_p[RB+SW-1:RB];
               rsp_data_in.minus_avg_rounded = round_m[RB+SW-1:RB];
               rsp_data_in.plus_avg_fixed    = q_plus_ff[FW-1:0];
               rsp_data_in.minus_avg_fixed   = div_quotient[FW-1:0];
               rsp_data_in.pairs_used        = n_hold_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CW'(1);
         peak_ff      <= '0;
         plus_sum_ff  <= '0;
         minus_sum_ff <= '0;
         pairs_ff     <= '0;
         minus_ch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         plus_sum_ff  <= plus_sum_in;
         minus_sum_ff <= minus_sum_in;
         pairs_ff     <= pairs_in;
         minus_ch_ff  <= minus_ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      minus_hold_ff <= minus_hold_in;
      n_hold_ff     <= n_hold_in;
      q_plus_ff     <= q_plus_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### verif/gppa_tb_pkg.sv
// Verification-side names for the gated peak pair averager.
// No dependencies; used by the checker and the testbench top through scoped names.
package gppa_tb_pkg;

   typedef enum logic {
      MODE_SAMPLE     = 1'b0,
      MODE_WINDOW_END = 1'b1
   } window_mode_type;

endpackage

### verif/gppa_checker.sv
// Scoreboard for the gated peak pair averager: rebuilds window peaks, channel sums and
// pair counts from observed transactions and checks every average result that is taken.
// Depends on gppa_pkg and gppa_tb_pkg.
module gppa_checker #(
   parameter int MAX_PULSES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire gppa_pkg::req_type             req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire gppa_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [gppa_pkg::COUNT_W-1:0]  csr_wr_data,
   output int                                 fail_count,
   output int                                 results_due
);

   logic [gppa_pkg::COUNT_W-1:0]  pair_target;
   logic [gppa_pkg::SAMPLE_W-1:0] peak;
   longint unsigned               plus_total;
   longint unsigned               minus_total;
   int unsigned                   pairs_closed;
   logic                          minus_side;
   gppa_pkg::rsp_type             averages_due[$];

   function automatic longint unsigned effective_pairs();
      longint unsigned n;
      n = longint'(pair_target);
      if (n < 1) n = 1;
      if (n > MAX_PULSES) n = MAX_PULSES;
      if (n > gppa_pkg::COUNT_LIMIT) n = gppa_pkg::COUNT_LIMIT;
      return n;
   endfunction

   function automatic void track_transaction(gppa_pkg::req_type item);
      longint unsigned   n;
      longint unsigned   rounded_plus;
      longint unsigned   rounded_minus;
      longint unsigned   fixed_plus;
      longint unsigned   fixed_minus;
      gppa_pkg::rsp_type avg;
      if (item.mode == gppa_tb_pkg::MODE_SAMPLE) begin
         if (item.sample > peak) peak = item.sample;
         return;
      end
      // window end: bank the peak on the current channel and flip
      if (!minus_side) begin
         plus_total = plus_total + longint'(peak);
         peak = '0;
         minus_side = 1'b1;
         return;
      end
      minus_total = minus_total + longint'(peak);
      peak = '0;
      minus_side = 1'b0;
      pairs_closed = (pairs_closed + 1) % 128;
      n = effective_pairs();
      if (pairs_closed < n) return;
      rounded_plus  = (2 * plus_total + n) / (2 * n);
      rounded_minus = (2 * minus_total + n) / (2 * n);
      fixed_plus    = (plus_total << gppa_pkg::FRAC_W) / n;
      fixed_minus   = (minus_total << gppa_pkg::FRAC_W) / n;
      avg.plus_avg_rounded  = rounded_plus[gppa_pkg::SAMPLE_W-1:0];
      avg.minus_avg_rounded = rounded_minus[gppa_pkg::SAMPLE_W-1:0];
      avg.plus_avg_fixed    = fixed_plus[gppa_pkg::FIXED_W-1:0];
      avg.minus_avg_fixed   = fixed_minus[gppa_pkg::FIXED_W-1:0];
      avg.pairs_used        = n[gppa_pkg::COUNT_W-1:0];
      averages_due.push_back(avg);
      plus_total = 0;
      minus_total = 0;
      pairs_closed = 0;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result(gppa_pkg::rsp_type got);
      gppa_pkg::rsp_type want;
      if (averages_due.size() == 0) begin
         $error("result transaction with no average pending");
         fail_count++;
         return;
      end
      want = averages_due.pop_front();
      check_field("plus_avg_rounded", longint'(want.plus_avg_rounded),
                  longint'(got.plus_avg_rounded));
      check_field("minus_avg_rounded", longint'(want.minus_avg_rounded),
                  longint'(got.minus_avg_rounded));
      check_field("plus_avg_fixed", longint'(want.plus_avg_fixed),
                  longint'(got.plus_avg_fixed));
      check_field("minus_avg_fixed", longint'(want.minus_avg_fixed),
                  longint'(got.minus_avg_fixed));
      check_field("pairs_used", longint'(want.pairs_used), longint'(got.pairs_used));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         pair_target = 1;
         peak = '0;
         plus_total = 0;
         minus_total = 0;
         pairs_closed = 0;
         minus_side = 1'b0;
         averages_due.delete();
      end else begin
         if (csr_wr_en) pair_target = csr_wr_data;
         if (req_valid && !req_stall) track_transaction(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      results_due = averages_due.size();
   end

endmodule

### verif/gated_peak_pair_averager_test.sv
// Testbench top for the gated peak pair averager: drives sample and window-end
// transactions, pulse count writes and result back-pressure; gppa_checker does the checks.
// Depends on gppa_pkg, gppa_tb_pkg, gppa_checker and the block itself.
module gated_peak_pair_averager_test;

   localparam int HALF_PERIOD   = 6;
   localparam int ITEM_TARGET   = 850;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int MAX_PULSES_TB = 64;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   gppa_pkg::req_type            req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   gppa_pkg::rsp_type            rsp_data;
   logic                         csr_wr_en;
   logic [gppa_pkg::COUNT_W-1:0] csr_wr_data;
   int                           fail_count;
   int                           results_due;
   int                           items_sent = 0;
   int                           cycle_count = 0;
   bit                           send_idle_on = 1'b1;
   bit                           recv_idle_on = 1'b1;
   bit                           hold_request = 1'b0;

   gated_peak_pair_averager dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gppa_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stall, plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= recv_idle_on && ($urandom_range(0, 99) < 11);
      end
   end

   function automatic logic [gppa_pkg::SAMPLE_W-1:0] random_sample();
      logic [gppa_pkg::SAMPLE_W-1:0] s;
      case ($urandom_range(0, 7))
         0: s = '1;
         1: s = '0;
         2: s = gppa_pkg::SAMPLE_W'(1) << $urandom_range(0, gppa_pkg::SAMPLE_W - 1);
         3: s = ~(gppa_pkg::SAMPLE_W'(1) << $urandom_range(0, gppa_pkg::SAMPLE_W - 1));
         default: s = gppa_pkg::SAMPLE_W'($urandom_range(0, 4095));
      endcase
      return s;
   endfunction

   function automatic logic [gppa_pkg::COUNT_W-1:0] random_count();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         2: return gppa_pkg::COUNT_W'($urandom_range(MAX_PULSES_TB + 1,
                                                     gppa_pkg::COUNT_LIMIT - 1));
         default: return gppa_pkg::COUNT_W'($urandom_range(1, 6));
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input gppa_tb_pkg::window_mode_type mode,
                        input logic [gppa_pkg::SAMPLE_W-1:0] smp);
      gppa_pkg::req_type item;
      while (send_idle_on && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      item.mode = mode;
      item.sample = smp;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic program_count(input logic [gppa_pkg::COUNT_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drop valid, wait out pending averages and any divide still in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_window(input int longest);
      int samples;
      if ($urandom_range(0, 99) < 8) begin
         // stray transaction: breaks the sample/window-end rhythm
         offer($urandom_range(0, 1) ? gppa_tb_pkg::MODE_WINDOW_END
                                    : gppa_tb_pkg::MODE_SAMPLE, random_sample());
         return;
      end
      samples = $urandom_range(0, longest);
      repeat (samples) offer(gppa_tb_pkg::MODE_SAMPLE, random_sample());
      offer(gppa_tb_pkg::MODE_WINDOW_END, random_sample());
   endtask

   initial begin
      int phase;
      int windows;
      int longest;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero count acts as one; empty minus window, sample field ignored on window end
      program_count('0);
      offer(gppa_tb_pkg::MODE_SAMPLE, '1);
      offer(gppa_tb_pkg::MODE_SAMPLE, '0);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '1);
      settle();

      // two pairs toward a count of three, then lower the count mid-measurement
      program_count(gppa_pkg::COUNT_W'(3));
      offer(gppa_tb_pkg::MODE_SAMPLE, 12'h555);
      offer(gppa_tb_pkg::MODE_SAMPLE, 12'hAAA);
      offer(gppa_tb_pkg::MODE_SAMPLE, 12'h800);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      offer(gppa_tb_pkg::MODE_SAMPLE, 12'h001);
      offer(gppa_tb_pkg::MODE_WINDOW_END, 12'h7FF);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      settle();
      program_count(gppa_pkg::COUNT_W'(1));
      offer(gppa_tb_pkg::MODE_SAMPLE, '1);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      offer(gppa_tb_pkg::MODE_SAMPLE, 12'hFFE);
      offer(gppa_tb_pkg::MODE_WINDOW_END, '0);
      settle();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         send_idle_on = (phase != 2);
         recv_idle_on = (phase != 2);
         case (phase)
            1: begin
               // count above MAX_PULSES: clamps to the full pair budget
               program_count('1);
               windows = 2 * MAX_PULSES_TB;
               longest = 1;
            end
            2: begin
               program_count(random_count());
               windows = 20;
               longest = 3;
            end
            3: begin
               // back-to-back results against a long result hold-off
               program_count(gppa_pkg::COUNT_W'(1));
               hold_request = 1'b1;
               windows = 40;
               longest = 2;
            end
            default: begin
               program_count(random_count());
               windows = $urandom_range(1, 30);
               longest = $urandom_range(0, 5);
            end
         endcase
         repeat (windows) send_window(longest);
         settle();
      end

      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
